// File: sv/gsda_pkg.sv
package gsda_pkg;

   // Pipeline depth default and the atan table length that caps it.
   localparam int CORDIC_STAGES_DEFAULT = 16;
   localparam int ATAN_TABLE_LEN        = 32;

   // Fixed-point constants (Q16).
   localparam int FPS_TO_KT_Q16 = 38829;
   localparam int GAIN_INV_Q16  = 39797;

   // Datapath widths.
   localparam int ROT_W  = 34;   // rotation x / y
   localparam int ROT_ZW = 34;   // rotation angle accumulator
   localparam int KT_W   = 17;   // body velocity in 1/16 kt
   localparam int UV_W   = ROT_W - 16;  // ground velocity before saturation
   localparam int VEC_W  = 37;   // vectoring x / y
   localparam int VEC_ZW = 34;   // vectoring angle accumulator
   localparam int MAG_W  = 18;   // magnitude before saturation

   typedef struct packed {
      logic [15:0]        heading_angle;
      logic [15:0]        wind_from_angle;
      logic [13:0]        wind_magnitude;
      logic signed [15:0] body_u_velocity;
      logic signed [15:0] body_v_velocity;
   } req_type;

   typedef struct packed {
      logic signed [15:0] drift_u;
      logic signed [15:0] drift_v;
      logic [15:0]        drift_speed;
      logic signed [15:0] drift_angle;
   } rsp_type;

   // Data handed from one rotation cell to the next.
   typedef struct packed {
      logic                     valid;
      logic signed [ROT_W-1:0]  x;
      logic signed [ROT_W-1:0]  y;
      logic signed [ROT_ZW-1:0] z;
      logic signed [KT_W-1:0]   bu_kt;
      logic signed [KT_W-1:0]   bv_kt;
   } rot_type;

   // Data handed from one vectoring cell to the next.
   typedef struct packed {
      logic                     valid;
      logic signed [VEC_W-1:0]  x;
      logic signed [VEC_W-1:0]  y;
      logic signed [VEC_ZW-1:0] z;
      logic signed [15:0]       drift_u;
      logic signed [15:0]       drift_v;
      logic                     zero;
   } vec_type;

   // atan(2^-i), 2^32 units per turn, rounded to nearest.
   function automatic logic [31:0] atan_entry(input int idx);
      logic [31:0] val;
      case (idx)
         0:  val = 32'd536870912;
         1:  val = 32'd316933406;
         2:  val = 32'd167458907;
         3:  val = 32'd85004756;
         4:  val = 32'd42667331;
         5:  val = 32'd21354465;
         6:  val = 32'd10679838;
         7:  val = 32'd5340245;
         8:  val = 32'd2670163;
         9:  val = 32'd1335087;
         10: val = 32'd667544;
         11: val = 32'd333772;
         12: val = 32'd166886;
         13: val = 32'd83443;
         14: val = 32'd41722;
         15: val = 32'd20861;
         16: val = 32'd10430;
         17: val = 32'd5215;
         18: val = 32'd2608;
         19: val = 32'd1304;
         20: val = 32'd652;
         21: val = 32'd326;
         22: val = 32'd163;
         23: val = 32'd81;
         24: val = 32'd41;
         25: val = 32'd20;
         26: val = 32'd10;
         27: val = 32'd5;
         28: val = 32'd3;
         29: val = 32'd1;
         30: val = 32'd1;
         default: val = 32'd0;
      endcase
      return val;
   endfunction

endpackage

// File: sv/ground_speed_drift_angle_core.sv
// Ground speed / drift angle from the wind triangle. Each request transaction carries
// heading, wind-from direction, wind speed (1/16 kt) and body u/v velocity (1/16 ft/s);
// the matching response carries ground velocity u/v (1/16 kt, saturated), ground speed
// and drift angle atan2(v,u) as a signed binary angle. While the serviceable register
// is clear, request transactions are consumed and produce no response. The block takes
// one transaction per clock unless a response is stalled; the path is the two rows
// of CORDIC cells (rotation, then vectoring) plus six registered stages around them.
// A stalled response freezes the whole pipeline, so req_stall follows rsp_stall
// while a response is waiting. No state is kept between transactions.
module ground_speed_drift_angle_core #(
   parameter int CORDIC_STAGES = gsda_pkg::CORDIC_STAGES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  gsda_pkg::req_type req_data,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gsda_pkg::rsp_type rsp_data,
   // control register
   input  logic              csr_write_enable,
   input  logic              csr_write_data
);

   // Number of cells per CORDIC row; the atan table caps it.
   localparam int NUM_CELLS = (CORDIC_STAGES > gsda_pkg::ATAN_TABLE_LEN) ?
                              gsda_pkg::ATAN_TABLE_LEN : CORDIC_STAGES;

   localparam int ROT_W  = gsda_pkg::ROT_W;
   localparam int UV_W   = gsda_pkg::UV_W;
   localparam int VEC_W  = gsda_pkg::VEC_W;
   localparam int VEC_ZW = gsda_pkg::VEC_ZW;
   localparam int MAG_W  = gsda_pkg::MAG_W;
   localparam int KT_PROD_W  = 33;               // 16 x 17 bit signed product
   localparam int MAG_PROD_W = VEC_W + 17;       // x times gain constant

   localparam logic signed [ROT_W-1:0] GAIN_ROT =
      ROT_W'(gsda_pkg::GAIN_INV_Q16);
   localparam logic signed [MAG_PROD_W-1:0] GAIN_MAG =
      MAG_PROD_W'(gsda_pkg::GAIN_INV_Q16);
   localparam logic signed [KT_PROD_W-1:0] FPS_TO_KT =
      KT_PROD_W'(gsda_pkg::FPS_TO_KT_Q16);

   //------------------------------------------------------------------------
   // Flow control: every stage moves unless a response sits stalled.
   //------------------------------------------------------------------------
   logic advance;
   logic rsp_valid_ff;
   logic serviceable_ff;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // serviceable register, set out of reset
   always_ff @(posedge clock) begin
      if (reset) begin
         serviceable_ff <= 1'b1;
      end else if (csr_write_enable) begin
         serviceable_ff <= csr_write_data;
      end
   end

   //------------------------------------------------------------------------
   // Entry stage: relative wind angle and quadrant fold.
   // Beyond a quarter turn the start vector is negated and a half turn is
   // removed; in 16-bit wrap that is a flip of the top bit.
   //------------------------------------------------------------------------
   logic [15:0]        rel_angle;
   logic signed [15:0] rel_signed;
   logic               fold;

   logic               entry_valid_ff, entry_valid_in;
   logic signed [15:0] entry_angle_ff, entry_angle_in;
   logic               entry_fold_ff;
   logic [13:0]        entry_speed_ff;
   logic signed [15:0] entry_bu_ff;
   logic signed [15:0] entry_bv_ff;

   assign rel_angle  = req_data.heading_angle - req_data.wind_from_angle;
   assign rel_signed = $signed(rel_angle);
   assign fold       = (rel_signed > 16'sd16384) || (rel_signed < -16'sd16384);

   assign entry_valid_in = req_valid && serviceable_ff;
   assign entry_angle_in = fold ? $signed({~rel_angle[15], rel_angle[14:0]}) : rel_signed;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else if (advance) begin
         entry_valid_ff <= entry_valid_in;
         entry_angle_ff <= entry_angle_in;
         entry_fold_ff  <= fold;
         entry_speed_ff <= req_data.wind_magnitude;
         entry_bu_ff    <= req_data.body_u_velocity;
         entry_bv_ff    <= req_data.body_v_velocity;
      end
   end

   //------------------------------------------------------------------------
   // Multiply stage: gain-compensated wind start vector, body ft/s to kt.
   //------------------------------------------------------------------------
   logic signed [ROT_W-1:0]     speed_ext;
   logic signed [KT_PROD_W-1:0] bu_ext, bv_ext;
   logic signed [KT_PROD_W-1:0] bu_prod, bv_prod;

   gsda_pkg::rot_type rot_stage [NUM_CELLS+1];
   gsda_pkg::rot_type prod_ff, prod_in;

   always_comb begin
      speed_ext = ROT_W'(entry_speed_ff);
      if (entry_fold_ff) begin
         speed_ext = -speed_ext;
      end
      bu_ext  = KT_PROD_W'(entry_bu_ff);
      bv_ext  = KT_PROD_W'(entry_bv_ff);
      bu_prod = bu_ext * FPS_TO_KT + KT_PROD_W'(32768);
      bv_prod = bv_ext * FPS_TO_KT + KT_PROD_W'(32768);

      prod_in.valid = entry_valid_ff;
      prod_in.x     = speed_ext * GAIN_ROT;
      prod_in.y     = '0;
      prod_in.z     = gsda_pkg::ROT_ZW'($signed({entry_angle_ff, 16'h0000}));
      prod_in.bu_kt = bu_prod[KT_PROD_W-1:16];
      prod_in.bv_kt = bv_prod[KT_PROD_W-1:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_ff.valid <= 1'b0;
      end else if (advance) begin
         prod_ff <= prod_in;
      end
   end

   assign rot_stage[0] = prod_ff;

   //------------------------------------------------------------------------
   // Rotation row: wind vector turned by the relative angle.
   //------------------------------------------------------------------------
   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_rot
      gsda_rot_cell #(
         .STAGE (i)
      ) u_rot_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .up_data   (rot_stage[i]),
         .down_data (rot_stage[i+1])
      );
   end

   //------------------------------------------------------------------------
   // Combine stage: u = body u - wind u, v = body v + wind v.
   //------------------------------------------------------------------------
   logic signed [ROT_W-1:0] wind_x_round, wind_y_round;
   logic                    comb_valid_ff;
   logic signed [UV_W-1:0]  comb_u_ff, comb_u_in;
   logic signed [UV_W-1:0]  comb_v_ff, comb_v_in;

   assign wind_x_round = rot_stage[NUM_CELLS].x + ROT_W'(32768);
   assign wind_y_round = rot_stage[NUM_CELLS].y + ROT_W'(32768);
   assign comb_u_in = UV_W'(rot_stage[NUM_CELLS].bu_kt) - $signed(wind_x_round[ROT_W-1:16]);
   assign comb_v_in = UV_W'(rot_stage[NUM_CELLS].bv_kt) + $signed(wind_y_round[ROT_W-1:16]);

   always_ff @(posedge clock) begin
      if (reset) begin
         comb_valid_ff <= 1'b0;
      end else if (advance) begin
         comb_valid_ff <= rot_stage[NUM_CELLS].valid;
         comb_u_ff     <= comb_u_in;
         comb_v_ff     <= comb_v_in;
      end
   end

   //------------------------------------------------------------------------
   // Vector preparation: right half-plane fold, saturated drift components.
   //------------------------------------------------------------------------
   gsda_pkg::vec_type vec_stage [NUM_CELLS+1];
   gsda_pkg::vec_type vprep_ff, vprep_in;

   logic                   u_negative;
   logic signed [UV_W-1:0] u_fold, v_fold;

   function automatic logic signed [15:0] sat16(input logic signed [UV_W-1:0] val);
      logic signed [15:0] res;
      if (val > UV_W'(32767)) begin
         res = 16'sh7FFF;
      end else if (val < -UV_W'(32768)) begin
         res = 16'sh8000;
      end else begin
         res = val[15:0];
      end
      return res;
   endfunction

   always_comb begin
      u_negative = comb_u_ff[UV_W-1];
      u_fold     = u_negative ? -comb_u_ff : comb_u_ff;
      v_fold     = u_negative ? -comb_v_ff : comb_v_ff;

      vprep_in.valid   = comb_valid_ff;
      vprep_in.x       = $signed({VEC_W'(u_fold)}) <<< 16;
      vprep_in.y       = $signed({VEC_W'(v_fold)}) <<< 16;
      vprep_in.z       = u_negative ? VEC_ZW'(64'h8000_0000) : '0;
      vprep_in.drift_u = sat16(comb_u_ff);
      vprep_in.drift_v = sat16(comb_v_ff);
      vprep_in.zero    = (comb_u_ff == '0) && (comb_v_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vprep_ff.valid <= 1'b0;
      end else if (advance) begin
         vprep_ff <= vprep_in;
      end
   end

   assign vec_stage[0] = vprep_ff;

   //------------------------------------------------------------------------
   // Vectoring row: magnitude and atan2 of the ground vector.
   //------------------------------------------------------------------------
   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_vec
      gsda_vec_cell #(
         .STAGE (i)
      ) u_vec_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .up_data   (vec_stage[i]),
         .down_data (vec_stage[i+1])
      );
   end

   //------------------------------------------------------------------------
   // Magnitude stage: gain compensation, angle rounding, zero vector.
   //------------------------------------------------------------------------
   logic signed [MAG_PROD_W-1:0] mag_prod;
   logic signed [VEC_ZW-1:0]     angle_round;

   logic               mag_valid_ff;
   logic [MAG_W-1:0]   mag_raw_ff, mag_raw_in;
   logic signed [15:0] mag_angle_ff, mag_angle_in;
   logic signed [15:0] mag_u_ff, mag_v_ff;

   assign mag_prod    = MAG_PROD_W'(vec_stage[NUM_CELLS].x) * GAIN_MAG
                        + MAG_PROD_W'(64'h8000_0000);
   assign angle_round = vec_stage[NUM_CELLS].z + VEC_ZW'(32768);
   assign mag_raw_in  = vec_stage[NUM_CELLS].zero ? '0 : mag_prod[32+MAG_W-1:32];
   assign mag_angle_in = vec_stage[NUM_CELLS].zero ? '0 : $signed(angle_round[31:16]);

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_valid_ff <= 1'b0;
      end else if (advance) begin
         mag_valid_ff <= vec_stage[NUM_CELLS].valid;
         mag_raw_ff   <= mag_raw_in;
         mag_angle_ff <= mag_angle_in;
         mag_u_ff     <= vec_stage[NUM_CELLS].drift_u;
         mag_v_ff     <= vec_stage[NUM_CELLS].drift_v;
      end
   end

   //------------------------------------------------------------------------
   // Response register: speed saturation, holds while stalled.
   //------------------------------------------------------------------------
   gsda_pkg::rsp_type rsp_data_ff, rsp_data_in;

   always_comb begin
      rsp_data_in.drift_u     = mag_u_ff;
      rsp_data_in.drift_v     = mag_v_ff;
      rsp_data_in.drift_speed = (mag_raw_ff > MAG_W'(65535)) ? 16'hFFFF : mag_raw_ff[15:0];
      rsp_data_in.drift_angle = mag_angle_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= mag_valid_ff;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // Out-of-service transactions never enter the pipeline.
   a_gate_unserviceable: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !serviceable_ff) |=> !entry_valid_ff)
      else $error("transaction entered pipeline while out of service");

   // A finished result reaches the response register on the next move.
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (advance && mag_valid_ff) |=> rsp_valid_ff)
      else $error("result lost before response register");

   // A stall freezes the entry stage.
   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(entry_valid_ff))
      else $error("pipeline moved during response stall");

   // A zero ground vector reports zero speed and zero angle.
   a_zero_vector: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.drift_u == 16'sd0 && rsp_data.drift_v == 16'sd0)
      |-> (rsp_data.drift_speed == 16'd0 && rsp_data.drift_angle == 16'sd0))
      else $error("zero ground vector with nonzero speed or angle");
`endif

endmodule

// File: sv/gsda_rot_cell.sv
// One rotation-mode CORDIC step: drives z toward zero.
module gsda_rot_cell #(
   parameter int STAGE = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  gsda_pkg::rot_type up_data,
   output gsda_pkg::rot_type down_data
);

   localparam logic signed [gsda_pkg::ROT_ZW-1:0] ATAN_STEP =
      gsda_pkg::ROT_ZW'(gsda_pkg::atan_entry(STAGE));

   gsda_pkg::rot_type cell_ff;
   gsda_pkg::rot_type cell_in;

   logic signed [gsda_pkg::ROT_W-1:0] x_shift;
   logic signed [gsda_pkg::ROT_W-1:0] y_shift;

   assign x_shift = $signed(up_data.x) >>> STAGE;
   assign y_shift = $signed(up_data.y) >>> STAGE;

   always_comb begin
      cell_in = up_data;
      if (!up_data.z[gsda_pkg::ROT_ZW-1]) begin
         cell_in.x = up_data.x - y_shift;
         cell_in.y = up_data.y + x_shift;
         cell_in.z = up_data.z - ATAN_STEP;
      end else begin
         cell_in.x = up_data.x + y_shift;
         cell_in.y = up_data.y - x_shift;
         cell_in.z = up_data.z + ATAN_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (advance) begin
         cell_ff <= cell_in;
      end
   end

   assign down_data = cell_ff;

endmodule

// File: sv/gsda_vec_cell.sv
// One vectoring-mode CORDIC step: drives y toward zero, sums angle in z.
module gsda_vec_cell #(
   parameter int STAGE = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  gsda_pkg::vec_type up_data,
   output gsda_pkg::vec_type down_data
);

   localparam logic signed [gsda_pkg::VEC_ZW-1:0] ATAN_STEP =
      gsda_pkg::VEC_ZW'(gsda_pkg::atan_entry(STAGE));

   gsda_pkg::vec_type cell_ff;
   gsda_pkg::vec_type cell_in;

   logic signed [gsda_pkg::VEC_W-1:0] x_shift;
   logic signed [gsda_pkg::VEC_W-1:0] y_shift;
   logic                              y_positive;

   assign x_shift    = $signed(up_data.x) >>> STAGE;
   assign y_shift    = $signed(up_data.y) >>> STAGE;
   assign y_positive = !up_data.y[gsda_pkg::VEC_W-1] && (up_data.y != '0);

   always_comb begin
      cell_in = up_data;
      if (y_positive) begin
         cell_in.x = up_data.x + y_shift;
         cell_in.y = up_data.y - x_shift;
         cell_in.z = up_data.z + ATAN_STEP;
      end else begin
         cell_in.x = up_data.x - y_shift;
         cell_in.y = up_data.y + x_shift;
         cell_in.z = up_data.z - ATAN_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (advance) begin
         cell_ff <= cell_in;
      end
   end

   assign down_data = cell_ff;

endmodule

// File: dv/tb_ground_speed_drift_angle_core.sv
`timescale 1ns / 1ps

module tb_ground_speed_drift_angle_core;

   // Pipeline depth under test and the matching pipeline latency.
   localparam int STAGES       = gsda_pkg::CORDIC_STAGES_DEFAULT;
   localparam int PIPE_LATENCY = 2 * STAGES + 6;
   // Watchdog limit; leave a wide margin over the slowest legal run.
   localparam int CYCLE_LIMIT  = 400000;

   // ---------------------------------------------------------------------
   // DUT signals: every input starts at a known value at time zero.
   // ---------------------------------------------------------------------
   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              req_valid        = 1'b0;
   logic              req_stall;
   gsda_pkg::req_type req_data         = '0;
   logic              rsp_valid;
   logic              rsp_stall        = 1'b0;
   gsda_pkg::rsp_type rsp_data;
   logic              csr_write_enable = 1'b0;
   logic              csr_write_data   = 1'b0;

   // ---------------------------------------------------------------------
   // Testbench state
   // ---------------------------------------------------------------------
   gsda_pkg::rsp_type expected_drift_q[$];   // predicted responses, oldest first
   logic    service_model = 1'b1;  // shadow of the serviceable register
   longint  atan_q32[gsda_pkg::ATAN_TABLE_LEN];
   int      mismatch_count  = 0;
   int      results_checked = 0;
   int      items_sent      = 0;
   int      cycle_count     = 0;
   bit      req_idle_en     = 1'b1;  // random gaps on the request side
   bit      rsp_idle_en     = 1'b1;  // random stall bursts on the response side
   int      hold_request    = 0;     // long response hold-off asked by a test
   int      hold_left       = 0;
   int      stall_left      = 0;

   ground_speed_drift_angle_core #(
      .CORDIC_STAGES(STAGES)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Wind triangle predictor. Plain 64-bit integer math; >>> on a signed
   // longint is a floor shift, which is what the datapath rounding assumes.
   // ---------------------------------------------------------------------
   function automatic gsda_pkg::rsp_type predict_ground_vector(input gsda_pkg::req_type item);
      logic signed [15:0] rel16;
      longint rel, ws, bu, bv, x, y, z, nx, wu, wv, u, v, mag, ang;
      gsda_pkg::rsp_type res;
      rel16 = item.heading_angle - item.wind_from_angle;
      rel   = longint'(rel16);
      ws    = longint'(item.wind_magnitude);
      bu    = longint'(item.body_u_velocity);
      bv    = longint'(item.body_v_velocity);

      // Rotate wind speed by the relative angle; fold beyond a quarter turn.
      x = ws * gsda_pkg::GAIN_INV_Q16;
      y = 0;
      if (rel > 16384) begin
         x   = -x;
         rel = rel - 32768;
      end else if (rel < -16384) begin
         x   = -x;
         rel = rel + 32768;
      end
      z = rel * 65536;
      for (int i = 0; i < STAGES && i < gsda_pkg::ATAN_TABLE_LEN; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - atan_q32[i];
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + atan_q32[i];
         end
         x = nx;
      end
      wu = (x + 32768) >>> 16;
      wv = (y + 32768) >>> 16;

      // Body velocity to knots, then subtract/add the wind parts.
      u = ((bu * gsda_pkg::FPS_TO_KT_Q16 + 32768) >>> 16) - wu;
      v = ((bv * gsda_pkg::FPS_TO_KT_Q16 + 32768) >>> 16) + wv;

      // Vectoring: magnitude and atan2; left half plane starts at half a turn.
      x = u * 65536;
      y = v * 65536;
      z = 0;
      if (u < 0) begin
         x = -x;
         y = -y;
         z = 64'sd2147483648;
      end
      for (int i = 0; i < STAGES && i < gsda_pkg::ATAN_TABLE_LEN; i++) begin
         if (y > 0) begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z  = z + atan_q32[i];
         end else begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z  = z - atan_q32[i];
         end
         x = nx;
      end
      if (u == 0 && v == 0) begin
         mag = 0;
         ang = 0;
      end else begin
         mag = (x * gsda_pkg::GAIN_INV_Q16 + 64'sd2147483648) >>> 32;
         ang = (z + 32768) >>> 16;
      end
      if (mag > 65535) mag = 65535;
      if (mag < 0) mag = 0;

      res.drift_u     = (u > 32767) ? 16'sd32767 : (u < -32768) ? -16'sd32768 : u[15:0];
      res.drift_v     = (v > 32767) ? 16'sd32767 : (v < -32768) ? -16'sd32768 : v[15:0];
      res.drift_speed = mag[15:0];
      res.drift_angle = ang[15:0];
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Mismatch reporting and response checking
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("MISMATCH @%0t %s: got %h expected %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_field(input string what, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   // A response transaction completes at a rising edge with valid high and
   // stall low; compare it against the oldest prediction.
   always @(posedge clock) begin
      gsda_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_drift_q.size() == 0) begin
            report_mismatch("unexpected response, drift_u", rsp_data.drift_u, 16'h0);
         end else begin
            want = expected_drift_q.pop_front();
            check_field("drift_u", rsp_data.drift_u, want.drift_u);
            check_field("drift_v", rsp_data.drift_v, want.drift_v);
            check_field("drift_speed", rsp_data.drift_speed, want.drift_speed);
            check_field("drift_angle", rsp_data.drift_angle, want.drift_angle);
            results_checked++;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response side: short random stall bursts, plus a long hold-off that a
   // test can ask for through hold_request.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (rsp_idle_en && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 2);   // random burst length
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, expected_drift_q.size());
      $display("RESULT: ERROR");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Request side. Called and returns at a falling edge; the payload is held
   // until the transaction is taken.
   // ---------------------------------------------------------------------
   task automatic send_request(input gsda_pkg::req_type item);
      int gap;
      if (req_idle_en && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      items_sent++;
      if (service_model) expected_drift_q.push_back(predict_ground_vector(item));
      @(negedge clock);
   endtask

   // Drop valid, wait for every predicted response, then let the pipe empty
   // of transactions that produce none.
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (expected_drift_q.size() != 0) @(negedge clock);
      repeat (PIPE_LATENCY + 8) @(negedge clock);
   endtask

   task automatic write_serviceable(input logic value);
      wait_for_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      service_model = value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic gsda_pkg::req_type make_request(input logic [15:0] heading,
                                                      input logic [15:0] wind_from,
                                                      input logic [13:0] speed,
                                                      input logic [15:0] bu,
                                                      input logic [15:0] bv);
      gsda_pkg::req_type item;
      item.heading_angle   = heading;
      item.wind_from_angle = wind_from;
      item.wind_magnitude  = speed;
      item.body_u_velocity = bu;
      item.body_v_velocity = bv;
      return item;
   endfunction

   // Half the requests keep uniform fields; the rest aim at near-zero vectors, quadrant
   // boundaries of the relative angle, field extremes and cruise-like values.
   function automatic gsda_pkg::req_type random_request();
      gsda_pkg::req_type item;
      logic [15:0] quarter;
      item.heading_angle   = 16'($urandom);
      item.wind_from_angle = 16'($urandom);
      item.wind_magnitude  = 14'($urandom);
      item.body_u_velocity = 16'($urandom);
      item.body_v_velocity = 16'($urandom);
      case ($urandom_range(0, 9))
         5: begin
            item.wind_magnitude  = 14'($urandom_range(0, 3));
            item.body_u_velocity = 16'($urandom_range(0, 8)) - 16'd4;
            item.body_v_velocity = 16'($urandom_range(0, 8)) - 16'd4;
         end
         6: begin
            quarter = 16'($urandom_range(0, 3)) << 14;
            item.wind_from_angle = item.heading_angle - quarter
                                   + 16'($urandom_range(0, 4)) - 16'd2;
         end
         7: begin
            if ($urandom_range(0, 1)) item.wind_magnitude = 14'h3FFF;
            if ($urandom_range(0, 1))
               item.body_u_velocity = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            if ($urandom_range(0, 1))
               item.body_v_velocity = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
         end
         8, 9: begin
            item.wind_magnitude  = 14'($urandom_range(0, 1200));
            item.body_u_velocity = 16'($urandom_range(2000, 9000));
            item.body_v_velocity = 16'($urandom_range(0, 800)) - 16'd400;
         end
         default: ;
      endcase
      return item;
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_directed_cases();
      send_request(make_request(16'h0000, 16'h0000, 14'h0000, 16'h0000, 16'h0000)); // zero vector
      send_request(make_request(16'hFFFF, 16'hFFFF, 14'h3FFF, 16'h7FFF, 16'h7FFF));
      send_request(make_request(16'h0000, 16'h0000, 14'h3FFF, 16'h8000, 16'h8000)); // u sat low
      send_request(make_request(16'h8000, 16'h0000, 14'h3FFF, 16'h7FFF, 16'h0000)); // u sat high
      send_request(make_request(16'h4000, 16'h0000, 14'h3FFF, 16'h0000, 16'h7FFF)); // v sat high
      send_request(make_request(16'hC000, 16'h0000, 14'h3FFF, 16'h0000, 16'h8000)); // v sat low
      // relative angle just past, and well past, a quarter turn both ways
      send_request(make_request(16'h4001, 16'h0000, 14'h2000, 16'h1000, 16'h0100));
      send_request(make_request(16'h0000, 16'h4001, 14'h2000, 16'h1000, 16'h0100));
      send_request(make_request(16'h7000, 16'h1000, 14'h1800, 16'h2000, 16'hFF00));
      send_request(make_request(16'h1000, 16'h7000, 14'h1800, 16'h2000, 16'hFF00));
      // ground vector straight back reads a half turn, then two cases near it
      send_request(make_request(16'h0000, 16'h0000, 14'h0000, 16'hFC18, 16'h0000));
      send_request(make_request(16'h2000, 16'h0100, 14'h0200, 16'hFC18, 16'h01F4));
      send_request(make_request(16'h2000, 16'h0100, 14'h0200, 16'hFC18, 16'hFE0C));
      send_request(make_request(16'h0000, 16'h0000, 14'd1000, 16'h0000, 16'h0000)); // wind only
      send_request(make_request(16'h0000, 16'h0000, 14'h0000, 16'h0000, 16'h0064)); // +90 deg
      send_request(make_request(16'h0000, 16'h0000, 14'h0000, 16'h0000, 16'hFF9C)); // -90 deg
      send_request(make_request(16'h0000, 16'h0000, 14'd16, 16'd27, 16'h0000));     // wind cancels
      send_request(make_request(16'h1234, 16'hFEDC, 14'h1555, 16'h3C3C, 16'hC3C3));
      send_request(make_request(16'hAAAA, 16'h5555, 14'h2AAA, 16'h5555, 16'hAAAA));
      send_request(make_request(16'h5555, 16'hAAAA, 14'h1555, 16'hAAAA, 16'h5555));
      send_request(make_request(16'h8000, 16'h8000, 14'h0001, 16'h0001, 16'hFFFF));
      wait_for_idle();
   endtask

   // Clearing serviceable swallows transactions; setting it brings results back.
   task automatic test_serviceable_off();
      write_serviceable(1'b0);
      repeat (20) send_request(random_request());
      write_serviceable(1'b1);
      write_serviceable(1'b1);
      repeat (10) send_request(random_request());
      wait_for_idle();
   endtask

   // Bulk random traffic with short unserviceable windows in between.
   task automatic test_random_traffic();
      for (int chunk = 0; chunk < 4; chunk++) begin
         repeat (225) send_request(random_request());
         write_serviceable(1'b0);
         repeat (5) send_request(random_request());
         write_serviceable(1'b1);
      end
   endtask

   // Response side held off long enough for the pipe to fill and push back
   // on requests, while requests keep coming back to back.
   task automatic test_backpressure();
      req_idle_en  = 1'b0;
      hold_request = 4 * PIPE_LATENCY + 100;
      repeat (150) send_request(random_request());
      req_idle_en = 1'b1;
      wait_for_idle();
   endtask

   // Request side pauses until every response is back, then resumes.
   task automatic test_sender_pause();
      repeat (30) send_request(random_request());
      req_valid <= 1'b0;
      while (expected_drift_q.size() != 0) @(negedge clock);
      repeat (30) send_request(random_request());
   endtask

   // Closing stretch at full rate, no idling on either side.
   task automatic test_full_rate();
      req_idle_en = 1'b0;
      rsp_idle_en = 1'b0;
      repeat (200) send_request(random_request());
      wait_for_idle();
   endtask

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   initial begin
      // atan(2^-i) in 2^32 units per turn, rounded to nearest
      for (int i = 0; i < gsda_pkg::ATAN_TABLE_LEN; i++)
         atan_q32[i] = longint'($rtoi($atan(1.0 / (2.0 ** i)) * 4294967296.0
                                       / 6.283185307179586 + 0.5));

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_cases();
      test_serviceable_off();
      test_random_traffic();
      test_backpressure();
      test_sender_pause();
      test_full_rate();
      wait_for_idle();

      $display("covered: %0d request transactions, %0d responses checked, %0d mismatches",
               items_sent, results_checked, mismatch_count);
      $display("serviceable toggled, long response hold-off, sender pause, full-rate tail");
      if (mismatch_count == 0 && expected_drift_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// File: files.f
sv/gsda_pkg.sv
sv/gsda_rot_cell.sv
sv/gsda_vec_cell.sv
sv/ground_speed_drift_angle_core.sv
dv/tb_ground_speed_drift_angle_core.sv
